// File: hdl/lsp_pkg.sv
// ----------------------------------------------------------------------------
// Line stepper package
// Shared widths, operation codes and the command record passed from the
// front end through the queue to the stepping engine.
// ----------------------------------------------------------------------------
package lsp_pkg;

    localparam int COORD_BITS  = 12;
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [COORD_BITS-1:0] t_delta;
    typedef logic signed [ERR_BITS-1:0]   t_err;

    // One classified command. Load commands carry the precomputed line setup.
    typedef struct packed {
        logic   op;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
        t_delta abs_dx;
        t_delta abs_dy;
        logic   neg_x;
        logic   neg_y;
        t_err   err_init;
        logic   degenerate;
    } t_cmd;

endpackage

// File: hdl/lsp_front.sv
// ----------------------------------------------------------------------------
// Line stepper front end
// Classifies each incoming item and, for loads, works out the step
// directions, absolute deltas and initial error term.
// ----------------------------------------------------------------------------
module lsp_front
    import lsp_pkg::*;
(
    input  logic   i_operation,
    input  t_coord i_start_x,
    input  t_coord i_start_y,
    input  t_coord i_end_x,
    input  t_coord i_end_y,
    output t_cmd   o_cmd
);

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic signed [COORD_BITS:0] mag_x;
    logic signed [COORD_BITS:0] mag_y;
    t_delta                     abs_dx;
    t_delta                     abs_dy;
    t_err                       half_dx;
    t_err                       half_dy;

    always_comb begin
        dx     = {i_end_x[COORD_BITS-1], i_end_x} - {i_start_x[COORD_BITS-1], i_start_x};
        dy     = {i_end_y[COORD_BITS-1], i_end_y} - {i_start_y[COORD_BITS-1], i_start_y};
        mag_x  = dx[COORD_BITS] ? -dx : dx;
        mag_y  = dy[COORD_BITS] ? -dy : dy;
        abs_dx = mag_x[COORD_BITS-1:0];
        abs_dy = mag_y[COORD_BITS-1:0];
        half_dx = t_err'({2'b00, abs_dx} >> 1);
        half_dy = t_err'({2'b00, abs_dy} >> 1);

        o_cmd.op         = i_operation;
        o_cmd.start_x    = i_start_x;
        o_cmd.start_y    = i_start_y;
        o_cmd.end_x      = i_end_x;
        o_cmd.end_y      = i_end_y;
        o_cmd.abs_dx     = abs_dx;
        o_cmd.abs_dy     = abs_dy;
        o_cmd.neg_x      = !(i_start_x < i_end_x);
        o_cmd.neg_y      = !(i_start_y < i_end_y);
        o_cmd.err_init   = (abs_dx > abs_dy) ? half_dx : -half_dy;
        o_cmd.degenerate = (i_start_x == i_end_x) && (i_start_y == i_end_y);
    end

endmodule

// File: hdl/lsp_cmd_queue.sv
// ----------------------------------------------------------------------------
// Line stepper command queue
// A short first-in first-out queue that decouples the front end from the
// stepping engine.
// ----------------------------------------------------------------------------
module lsp_cmd_queue
    import lsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QPTR_BITS-1:0] n_wr_ptr;
    logic [QPTR_BITS-1:0] n_rd_ptr;
    logic [QCNT_BITS-1:0] n_count;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");
    a_no_pop_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");
    a_count_tracks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on a lone push");
`endif

endmodule

// File: hdl/lsp_back.sv
// ----------------------------------------------------------------------------
// Line stepper engine
// Holds the line state, executes load and step commands one per cycle unless
// the result is stalled, and keeps the result in an output register.
// ----------------------------------------------------------------------------
module lsp_back
    import lsp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cmd_avail,
    input  t_cmd   i_cmd,
    output logic   o_cmd_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output t_coord o_pixel_x,
    output t_coord o_pixel_y,
    output logic   o_valid_res,
    output logic   o_last
);

    t_coord r_cur_x, r_cur_y, r_target_x, r_target_y;
    logic   r_neg_x, r_neg_y;
    t_delta r_abs_dx, r_abs_dy;
    t_err   r_err;
    logic   r_active;
    logic   r_out_valid;
    t_coord r_out_x, r_out_y;
    logic   r_out_valid_res, r_out_last;

    t_coord n_cur_x, n_cur_y, n_target_x, n_target_y;
    logic   n_neg_x, n_neg_y;
    t_delta n_abs_dx, n_abs_dy;
    t_err   n_err;
    logic   n_active;
    t_coord n_out_x, n_out_y;
    logic   n_out_valid_res, n_out_last;

    logic   pop;
    logic   move_x, move_y;
    t_err   ext_dx, ext_dy;
    logic   at_end;

    assign pop       = i_cmd_avail && (!r_out_valid || i_ready);
    assign o_cmd_pop = pop;
    assign ext_dx    = t_err'({2'b00, r_abs_dx});
    assign ext_dy    = t_err'({2'b00, r_abs_dy});
    // Both decisions look at the error value from before this step.
    assign move_x    = (r_err > -ext_dx);
    assign move_y    = (r_err < ext_dy);

    always_comb begin
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_target_x = r_target_x;
        n_target_y = r_target_y;
        n_neg_x    = r_neg_x;
        n_neg_y    = r_neg_y;
        n_abs_dx   = r_abs_dx;
        n_abs_dy   = r_abs_dy;
        n_err      = r_err;
        n_active   = r_active;
        n_out_x    = '0;
        n_out_y    = '0;
        n_out_valid_res = 1'b0;
        n_out_last = 1'b0;
        at_end     = 1'b0;
        case (i_cmd.op)
            OP_LOAD: begin
                n_cur_x    = i_cmd.start_x;
                n_cur_y    = i_cmd.start_y;
                n_target_x = i_cmd.end_x;
                n_target_y = i_cmd.end_y;
                n_neg_x    = i_cmd.neg_x;
                n_neg_y    = i_cmd.neg_y;
                n_abs_dx   = i_cmd.abs_dx;
                n_abs_dy   = i_cmd.abs_dy;
                n_err      = i_cmd.err_init;
                n_active   = !i_cmd.degenerate;
                n_out_x    = i_cmd.start_x;
                n_out_y    = i_cmd.start_y;
                n_out_valid_res = 1'b1;
                n_out_last = i_cmd.degenerate;
            end
            OP_STEP: begin
                if (r_active) begin
                    if (move_x) begin
                        n_cur_x = r_neg_x ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                    end
                    if (move_y) begin
                        n_cur_y = r_neg_y ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                    end
                    n_err = r_err - (move_x ? ext_dy : '0) + (move_y ? ext_dx : '0);
                    at_end = (n_cur_x == r_target_x) && (n_cur_y == r_target_y);
                    n_active = !at_end;
                    n_out_x  = n_cur_x;
                    n_out_y  = n_cur_y;
                    n_out_valid_res = 1'b1;
                    n_out_last = at_end;
                end
            end
            default: begin
                n_active = r_active;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x         <= '0;
            r_cur_y         <= '0;
            r_target_x      <= '0;
            r_target_y      <= '0;
            r_neg_x         <= 1'b0;
            r_neg_y         <= 1'b0;
            r_abs_dx        <= '0;
            r_abs_dy        <= '0;
            r_err           <= '0;
            r_active        <= 1'b0;
            r_out_valid     <= 1'b0;
            r_out_x         <= '0;
            r_out_y         <= '0;
            r_out_valid_res <= 1'b0;
            r_out_last      <= 1'b0;
        end else begin
            if (pop) begin
                r_cur_x         <= n_cur_x;
                r_cur_y         <= n_cur_y;
                r_target_x      <= n_target_x;
                r_target_y      <= n_target_y;
                r_neg_x         <= n_neg_x;
                r_neg_y         <= n_neg_y;
                r_abs_dx        <= n_abs_dx;
                r_abs_dy        <= n_abs_dy;
                r_err           <= n_err;
                r_active        <= n_active;
                r_out_valid     <= 1'b1;
                r_out_x         <= n_out_x;
                r_out_y         <= n_out_y;
                r_out_valid_res <= n_out_valid_res;
                r_out_last      <= n_out_last;
            end else if (i_ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_x   = r_out_x;
    assign o_pixel_y   = r_out_y;
    assign o_valid_res = r_out_valid_res;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    a_active_not_at_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> !((r_cur_x == r_target_x) && (r_cur_y == r_target_y)))
        else $error("line still active at its end point");
    a_last_is_target : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |->
            ((r_out_x == r_target_x) && (r_out_y == r_target_y)))
        else $error("last pixel differs from the end point");
    a_idle_result_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_valid_res) |->
            ((r_out_x == '0) && (r_out_y == '0) && !r_out_last))
        else $error("idle step result carries nonzero fields");
    a_no_pop_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !pop)
        else $error("command consumed while the result is stalled");
`endif

endmodule

// File: hdl/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper
// All-octant integer line generator: a load transfer sets up a line and
// returns its start pixel, each step transfer returns the next pixel.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle while the queue has space and
// returns exactly one result per item, in order. A load item (operation 0)
// latches signed start and end points and answers with the start pixel;
// each step item (operation 1) advances one pixel and answers with it, and
// last is set on the pixel that equals the end point, after which the line
// is inactive. A step with no active line answers with valid_res low and all
// other fields zero. When neither side stalls the sustained rate is one
// transfer per cycle in both directions: the stepping engine does its two
// error compares and adds combinationally. An item is registered first in
// the command queue and then in the output register. The two-entry queue
// and the output register let either side stall without stopping the other
// at once.
// ----------------------------------------------------------------------------
module bresenham_line_stepper
    import lsp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    // Input channel.
    input  logic   i_valid,
    output logic   o_ready,
    input  logic   i_operation,
    input  t_coord i_start_x,
    input  t_coord i_start_y,
    input  t_coord i_end_x,
    input  t_coord i_end_y,
    // Result channel.
    output logic   o_valid,
    input  logic   i_ready,
    output t_coord o_pixel_x,
    output t_coord o_pixel_y,
    output logic   o_valid_res,
    output logic   o_last
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_full;
    logic queue_empty;
    logic queue_pop;
    logic push;

    // The front end only needs space in the queue to take a transfer.
    assign o_ready = !queue_full;
    assign push    = i_valid && !queue_full;

    // Decode the item and precompute the line setup for loads.
    lsp_front u_front (
        .i_operation (i_operation),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_cmd       (front_cmd)
    );

    // Short queue between the front end and the stepping engine.
    lsp_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_cmd   (queue_cmd),
        .o_empty (queue_empty)
    );

    // The engine holds the line state and the registered result.
    lsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_avail (!queue_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_valid_res (o_valid_res),
        .o_last      (o_last)
    );

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper testbench
// Drives load and step transfers into the line stepper. A small scoreboard
// computes every expected pixel with its own line-stepping model and checks
// the result transfers in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import lsp_pkg::*;

    // Generous cycle limit.
    localparam int CYCLE_LIMIT = 400000;
    // Results pass through the command queue and the output register, so a short
    // settle time after the last result is enough.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 500;
    // Idling stops once this many items have been sent.
    localparam int CALM_AFTER = 420;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    logic   i_operation;
    t_coord i_start_x;
    t_coord i_start_y;
    t_coord i_end_x;
    t_coord i_end_y;
    logic   o_valid;
    logic   i_ready;
    t_coord o_pixel_x;
    t_coord o_pixel_y;
    logic   o_valid_res;
    logic   o_last;

    // One expected result transfer.
    typedef struct {
        t_coord x;
        t_coord y;
        logic   vres;
        logic   last;
    } t_pixel;

    // Keeps its own copy of the line state, predicts one pixel per accepted
    // command and checks the pixels that come out, oldest first.
    class line_scoreboard;
        t_coord cur_x, cur_y, tgt_x, tgt_y;
        logic   neg_x, neg_y;
        int     abs_dx, abs_dy;
        t_err   err;
        logic   active;
        t_pixel pending[$];
        int     fail_count;

        function new();
            cur_x = '0; cur_y = '0; tgt_x = '0; tgt_y = '0;
            neg_x = 1'b0; neg_y = 1'b0;
            abs_dx = 0; abs_dy = 0;
            err = '0;
            active = 1'b0;
            fail_count = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH: %s", msg);
            fail_count++;
        endtask

        task note_command(input logic op, input t_coord sx, input t_coord sy,
                          input t_coord ex, input t_coord ey);
            int     dx, dy, saved, e;
            logic   at_end;
            t_pixel p;
            if (op == OP_LOAD) begin
                dx = int'(ex) - int'(sx);
                dy = int'(ey) - int'(sy);
                neg_x = !(sx < ex);
                neg_y = !(sy < ey);
                abs_dx = (dx < 0) ? -dx : dx;
                abs_dy = (dy < 0) ? -dy : dy;
                if (abs_dx > abs_dy)
                    err = t_err'(abs_dx / 2);
                else
                    err = t_err'(-(abs_dy / 2));
                cur_x = sx; cur_y = sy;
                tgt_x = ex; tgt_y = ey;
                at_end = (sx == ex) && (sy == ey);
                active = !at_end;
                p = '{sx, sy, 1'b1, at_end};
            end else if (!active) begin
                // A step with no line answers with an all-zero pixel.
                p = '{'0, '0, 1'b0, 1'b0};
            end else begin
                // Both error tests look at the value from before this step.
                saved = int'(err);
                e = saved;
                if (saved > -abs_dx) begin
                    e -= abs_dy;
                    cur_x = t_coord'(int'(cur_x) + (neg_x ? -1 : 1));
                end
                if (saved < abs_dy) begin
                    e += abs_dx;
                    cur_y = t_coord'(int'(cur_y) + (neg_y ? -1 : 1));
                end
                err = t_err'(e);
                at_end = (cur_x == tgt_x) && (cur_y == tgt_y);
                active = !at_end;
                p = '{cur_x, cur_y, 1'b1, at_end};
            end
            pending = {pending, p};
        endtask

        task check_pixel(input t_coord px, input t_coord py, input logic vres,
                         input logic last);
            t_pixel p;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("pixel (%0d,%0d) with nothing expected", px, py));
            end else begin
                p = pending.pop_front();
                if (px !== p.x)
                    report_mismatch($sformatf("pixel_x %0d, expected %0d", px, p.x));
                if (py !== p.y)
                    report_mismatch($sformatf("pixel_y %0d, expected %0d", py, p.y));
                if (vres !== p.vres)
                    report_mismatch($sformatf("valid_res %b, expected %b", vres, p.vres));
                if (last !== p.last)
                    report_mismatch($sformatf("last %b, expected %b", last, p.last));
            end
        endtask
    endclass

    line_scoreboard sb = new();

    int items_sent;
    int cycle_count;
    bit sender_gaps;
    bit stalls_on;

    bresenham_line_stepper DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_valid_res (o_valid_res),
        .o_last      (o_last)
    );

    // Clock with a period of four time units.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Watchdog. Counting starts at time zero, so reset is included.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Every result transfer goes straight to the scoreboard. Outputs are
    // sampled at the rising edge, while the inputs only move at the falling
    // edge, so there is no race with the block's own registers.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1)
            sb.check_pixel(o_pixel_x, o_pixel_y, o_valid_res, o_last);
    end

    function automatic t_coord rand_coord();
        return t_coord'($urandom);
    endfunction

    // Presents one item and holds it until it is accepted. Called at a falling
    // edge and returns at a falling edge with valid still high, so that
    // back-to-back items leave no bubble. A random gap may come first.
    task automatic send_item(input logic op, input t_coord sx, input t_coord sy,
                             input t_coord ex, input t_coord ey);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_start_x   <= sx;
        i_start_y   <= sy;
        i_end_x     <= ex;
        i_end_y     <= ey;
        @(posedge i_clk);
        while (o_ready !== 1'b1)
            @(posedge i_clk);
        sb.note_command(op, sx, sy, ex, ey);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Step items ignore the coordinate fields, so they carry random junk.
    task automatic send_step();
        send_item(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    // Holds off the sender until every outstanding pixel has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge i_clk);
    endtask

    // Loads a random line whose deltas stay within max_delta and steps it.
    // A complete line is stepped to its end point, sometimes with a few more
    // steps that then fall on an idle block. An incomplete one is abandoned
    // part way, so the next load replaces a live line.
    task automatic draw_line(input int max_delta, input bit complete);
        int sx, sy, ex, ey, ax, ay, len, n;
        sx = int'($urandom_range(0, 4095)) - 2048;
        sy = int'($urandom_range(0, 4095)) - 2048;
        ex = sx + int'($urandom_range(0, 2 * max_delta)) - max_delta;
        ey = sy + int'($urandom_range(0, 2 * max_delta)) - max_delta;
        // Mirror an end point that would leave the coordinate range.
        if (ex > 2047 || ex < -2048)
            ex = 2 * sx - ex;
        if (ey > 2047 || ey < -2048)
            ey = 2 * sy - ey;
        ax = (ex > sx) ? ex - sx : sx - ex;
        ay = (ey > sy) ? ey - sy : sy - ey;
        len = (ax > ay) ? ax : ay;
        if (complete)
            n = len + (($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 2)) : 0);
        else if (len == 0)
            n = 0;
        else
            n = int'($urandom_range(0, (len - 1 < 24) ? len - 1 : 24));
        send_item(OP_LOAD, t_coord'(sx), t_coord'(sy), t_coord'(ex), t_coord'(ey));
        repeat (n) send_step();
    endtask

    // Result side: ready drops in random bursts, with calm stretches between,
    // and stays high for good once the last part of the run begins.
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stalls_on && $urandom_range(0, 11) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_ready <= 1'b1;
            end else if (stalls_on && $urandom_range(0, 59) == 0) begin
                i_ready <= 1'b1;
                repeat ($urandom_range(30, 90)) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        int  kind;
        bit  drained;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = OP_LOAD;
        i_start_x   = '0;
        i_start_y   = '0;
        i_end_x     = '0;
        i_end_y     = '0;
        items_sent  = 0;
        cycle_count = 0;
        sender_gaps = 1'b1;
        stalls_on   = 1'b1;
        drained     = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. A step straight out of reset finds no line.
        send_step();
        // Start equal to end: the load itself is the last pixel, and the
        // following step finds the block idle again.
        send_item(OP_LOAD, 12'sd0, 12'sd0, 12'sd0, 12'sd0);
        send_step();
        send_item(OP_LOAD, -12'sd2048, 12'sd2047, -12'sd2048, 12'sd2047);
        // Longest possible diagonal, corner to corner, then a load that
        // replaces it while it is still active with the opposite diagonal.
        send_item(OP_LOAD, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047);
        repeat (3) send_step();
        send_item(OP_LOAD, 12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047);
        repeat (3) send_step();
        // A shallow line with x as the major axis.
        send_item(OP_LOAD, 12'sd0, 12'sd0, 12'sd3, 12'sd1);
        repeat (3) send_step();
        // A steep line stepping toward negative x, run one step past its end.
        send_item(OP_LOAD, 12'sd5, 12'sd5, 12'sd4, 12'sd9);
        repeat (5) send_step();
        // A vertical line going down, with equal x on both ends.
        send_item(OP_LOAD, 12'sd0, 12'sd0, 12'sd0, -12'sd2);
        repeat (2) send_step();
        drain_results();

        // Random part. Mostly complete short lines with random placement,
        // some longer ones, lines abandoned part way with huge deltas, and
        // a little noise of arbitrary items.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            sender_gaps = (items_sent < CALM_AFTER) && ($urandom_range(0, 2) != 0);
            stalls_on   = (items_sent < CALM_AFTER);
            kind = $urandom_range(0, 19);
            if (kind <= 12) begin
                draw_line(12, 1'b1);
            end else if (kind <= 14) begin
                draw_line(48, 1'b1);
            end else if (kind <= 17) begin
                draw_line(2047, 1'b0);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(logic'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord());
            end
            // Once in mid run the sender waits for the pipeline to empty.
            if (!drained && items_sent >= RANDOM_ITEMS / 2) begin
                drain_results();
                drained = 1'b1;
            end
        end

        // Wind down: wait for every outstanding pixel, then a settle time in case
        // something unexpected trails behind.
        i_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d pixels never arrived", sb.pending.size()));
        if (sb.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
